### sv/lrs_pkg.sv
`timescale 1ns / 1ps
package lrs_pkg;

  localparam int NumFeatures = 8;
  localparam int SigDepth    = 256;

  localparam int FeatW     = 16;
  localparam int WeightW   = 32;
  localparam int CntW      = $clog2(NumFeatures + 1);
  localparam int FeatIdxW  = (NumFeatures > 1) ? $clog2(NumFeatures) : 1;
  localparam int SigIdxW   = $clog2(SigDepth);
  localparam int AccW      = WeightW + FeatW + CntW + 1;
  localparam int MulAW     = 33;
  localparam int MulBW     = 18;
  localparam int MulW      = MulAW + MulBW;
  localparam int ZW        = 20;
  localparam int IdxProdW  = ZW + SigIdxW + 1;

  localparam logic [FeatW-1:0] LrReset = 16'd6554;

  typedef logic [NumFeatures-1:0][FeatW-1:0] feat_arr_t;
  typedef logic [15:0] sig_rom_t [SigDepth];

  typedef enum logic [2:0] {
    MulDot,
    MulGain,
    MulErr,
    MulRate,
    MulLow,
    MulHigh
  } mul_op_e;

  typedef struct packed {
    logic            load;
    logic            mul_en;
    mul_op_e         mul_op;
    logic            acc_en;
    logic            idx_ld;
    logic            p_ld;
    logic            out_ld;
    logic            bias_upd;
    logic            lo_ld;
    logic            w_upd;
    logic [CntW-1:0] sel;
  } cmd_t;

  typedef struct packed {
    logic action;
    logic out_free;
  } sts_t;

  function automatic logic [WeightW-1:0] sat32(logic signed [WeightW:0] v);
    logic [WeightW-1:0] r;
    if (v[WeightW] != v[WeightW-1]) begin
      r = v[WeightW] ? {1'b1, {(WeightW-1){1'b0}}} : {1'b0, {(WeightW-1){1'b1}}};
    end else begin
      r = v[WeightW-1:0];
    end
    return r;
  endfunction

  // Restoring division, only used while the sigmoid table is elaborated.
  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // exp(-t) as exp(-t/256)^256: a fourth order series, then eight squarings.
  function automatic logic [15:0] sig_entry(logic signed [63:0] zq);
    logic [63:0] t;
    logic [63:0] v;
    logic [63:0] v2;
    logic [63:0] v3;
    logic [63:0] v4;
    logic [63:0] d;
    logic [63:0] den;
    logic [63:0] r;
    t  = (zq < 0) ? 64'(-zq) : 64'(zq);
    v  = t << 7;
    v2 = (v * v) >> 31;
    v3 = (v2 * v) >> 31;
    v4 = (v3 * v) >> 31;
    d  = 64'h8000_0000 - v + (v2 >> 1) - v3 / 6 + v4 / 24;
    for (int i = 0; i < 8; i++) begin
      d = (d * d + 64'h4000_0000) >> 31;
    end
    den = 64'h8000_0000 + d;
    if (zq >= 0) begin
      r = udiv64((64'd1 << 47) + (den >> 1), den);
    end else begin
      r = udiv64((d << 16) + (den >> 1), den);
    end
    if (r > 64'd65535) begin
      r = 64'd65535;
    end
    return r[15:0];
  endfunction

  function automatic sig_rom_t build_sig_rom();
    sig_rom_t rom;
    logic signed [63:0] zk;
    for (int k = 0; k < SigDepth; k++) begin
      zk = -64'sd524288 + 64'((64'(2 * k + 1) * 64'd524288) / SigDepth);
      rom[k] = sig_entry(zk);
    end
    return rom;
  endfunction

  localparam sig_rom_t SigRom = build_sig_rom();

endpackage

### sv/lrs_in_if.sv
`timescale 1ns / 1ps
interface lrs_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [15:0] feature_0;
  logic [15:0] feature_1;
  logic [15:0] feature_2;
  logic [15:0] feature_3;
  logic [15:0] feature_4;
  logic [15:0] feature_5;
  logic [15:0] feature_6;
  logic [15:0] feature_7;
  logic        label;

  modport source (
    output valid, action, feature_0, feature_1, feature_2, feature_3,
           feature_4, feature_5, feature_6, feature_7, label,
    input  ready
  );

  modport sink (
    input  valid, action, feature_0, feature_1, feature_2, feature_3,
           feature_4, feature_5, feature_6, feature_7, label,
    output ready
  );
endinterface

### sv/lrs_out_if.sv
`timescale 1ns / 1ps
interface lrs_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] probability;
  logic        predicted_class;
  logic        matches_label;

  modport source (
    output valid, probability, predicted_class, matches_label,
    input  ready
  );

  modport sink (
    input  valid, probability, predicted_class, matches_label,
    output ready
  );
endinterface

### sv/logistic_regression_sgd_step.sv
// Logistic regression with one gradient step per training sample.
// in_i carries one sample: action (0 predict, 1 predict and train), eight
// Q0.16 features and a 0/1 label. out_o returns one result per sample: the
// Q0.16 probability, the predicted class and whether it equals the label.
// The outputs always use the weights as they stood before the sample.
// cfg_we_i/cfg_wdata_i write the Q0.16 learning rate; write it only while
// the block is idle.
// A result passes through the dot product (one multiply per feature on the
// single shared multiplier), the table index and the table lookup, then is
// registered. A training sample then updates the bias and weights (three
// multiplies for the gain, then two multiplies and a write per weight
// through the same multiplier).
// in_i.ready is high only while the block is idle. The result register lets
// the next sample be taken while a result still waits; if the receiver
// stalls, the following result waits in the datapath until the register
// frees up. Reset clears the bias and weights to zero, sets the learning
// rate to 6554 and empties the result register.
`timescale 1ns / 1ps
module logistic_regression_sgd_step (
  input  logic        clk_i,
  input  logic        rst_ni,
  lrs_in_if.sink      in_i,
  lrs_out_if.source   out_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  lrs_pkg::cmd_t      cmd;
  lrs_pkg::sts_t      sts;
  lrs_pkg::feat_arr_t feat;

  assign feat[0] = in_i.feature_0;
  assign feat[1] = in_i.feature_1;
  assign feat[2] = in_i.feature_2;
  assign feat[3] = in_i.feature_3;
  assign feat[4] = in_i.feature_4;
  assign feat[5] = in_i.feature_5;
  assign feat[6] = in_i.feature_6;
  assign feat[7] = in_i.feature_7;

  lrs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lrs_datapath u_datapath (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cmd_i                 (cmd),
    .sts_o                 (sts),
    .action_i              (in_i.action),
    .label_i               (in_i.label),
    .feat_i                (feat),
    .cfg_we_i              (cfg_we_i),
    .cfg_wdata_i           (cfg_wdata_i),
    .out_ready_i           (out_o.ready),
    .out_valid_o           (out_o.valid),
    .out_probability_o     (out_o.probability),
    .out_predicted_class_o (out_o.predicted_class),
    .out_matches_label_o   (out_o.matches_label)
  );

endmodule

### sv/lrs_ctrl.sv
`timescale 1ns / 1ps
module lrs_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  lrs_pkg::sts_t sts_i,
  output lrs_pkg::cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DOT  = 4'd1;
  localparam logic [3:0] S_IDX  = 4'd2;
  localparam logic [3:0] S_LOOK = 4'd3;
  localparam logic [3:0] S_OUT  = 4'd4;
  localparam logic [3:0] S_GAIN = 4'd5;
  localparam logic [3:0] S_ERR  = 4'd6;
  localparam logic [3:0] S_RATE = 4'd7;
  localparam logic [3:0] S_BIAS = 4'd8;
  localparam logic [3:0] S_LOW  = 4'd9;
  localparam logic [3:0] S_HIGH = 4'd10;
  localparam logic [3:0] S_WUPD = 4'd11;

  localparam logic [lrs_pkg::CntW-1:0] CntDotEnd = lrs_pkg::CntW'(lrs_pkg::NumFeatures);
  localparam logic [lrs_pkg::CntW-1:0] CntUpdEnd = lrs_pkg::CntW'(lrs_pkg::NumFeatures - 1);

  logic [3:0]                state_q, state_d;
  logic [lrs_pkg::CntW-1:0]  cnt_q, cnt_d;
  logic                      load;

  assign in_ready_o = (state_q == S_IDLE);
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    cmd_o        = '0;
    cmd_o.mul_op = lrs_pkg::MulDot;
    cmd_o.sel    = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        if (load) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = S_DOT;
        end
      end
      S_DOT: begin
        // Multiply for feature cnt while the previous product is summed.
        cmd_o.mul_en = (cnt_q != CntDotEnd);
        cmd_o.acc_en = (cnt_q != '0);
        if (cnt_q == CntDotEnd) begin
          state_d = S_IDX;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_IDX: begin
        cmd_o.idx_ld = 1'b1;
        state_d      = S_LOOK;
      end
      S_LOOK: begin
        cmd_o.p_ld = 1'b1;
        state_d    = S_OUT;
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_ld = 1'b1;
          state_d      = sts_i.action ? S_GAIN : S_IDLE;
        end
      end
      S_GAIN: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = lrs_pkg::MulGain;
        state_d      = S_ERR;
      end
      S_ERR: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = lrs_pkg::MulErr;
        state_d      = S_RATE;
      end
      S_RATE: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = lrs_pkg::MulRate;
        state_d      = S_BIAS;
      end
      S_BIAS: begin
        cmd_o.bias_upd = 1'b1;
        cnt_d          = '0;
        state_d        = S_LOW;
      end
      S_LOW: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = lrs_pkg::MulLow;
        state_d      = S_HIGH;
      end
      S_HIGH: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = lrs_pkg::MulHigh;
        cmd_o.lo_ld  = 1'b1;
        state_d      = S_WUPD;
      end
      S_WUPD: begin
        cmd_o.w_upd = 1'b1;
        if (cnt_q == CntUpdEnd) begin
          state_d = S_IDLE;
        end else begin
          cnt_d   = cnt_q + 1'b1;
          state_d = S_LOW;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntDotEnd)
    else $error("feature counter out of range");

  a_load_starts_dot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (state_q == S_DOT) && (cnt_q == '0))
    else $error("accepted item did not start the dot product");

  a_out_ld_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_ld |-> sts_i.out_free)
    else $error("result loaded over a waiting result");

  a_upd_train: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.w_upd || cmd_o.bias_upd) |-> sts_i.action)
    else $error("weight update on a predict-only item");

endmodule

### sv/lrs_datapath.sv
`timescale 1ns / 1ps
module lrs_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lrs_pkg::cmd_t      cmd_i,
  output lrs_pkg::sts_t      sts_o,
  input  logic               action_i,
  input  logic               label_i,
  input  lrs_pkg::feat_arr_t feat_i,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [15:0]        out_probability_o,
  output logic               out_predicted_class_o,
  output logic               out_matches_label_o
);

  localparam int AccW = lrs_pkg::AccW;
  localparam int MulW = lrs_pkg::MulW;
  localparam int ZW   = lrs_pkg::ZW;

  logic [lrs_pkg::FeatW-1:0]         x_q [lrs_pkg::NumFeatures];
  logic signed [lrs_pkg::WeightW-1:0] w_q [lrs_pkg::NumFeatures+1];
  logic                              action_q;
  logic                              label_q;
  logic [15:0]                       lr_q;
  logic signed [AccW-1:0]            acc_q;
  logic signed [MulW-1:0]            prod_q;
  logic [lrs_pkg::SigIdxW-1:0]       idx_q, idx_d;
  logic [15:0]                       p_q;
  logic signed [47:0]                c_q;
  logic [40:0]                       lo_q;
  logic                              out_valid_q;
  logic [15:0]                       out_prob_q;
  logic                              out_cls_q;
  logic                              out_match_q;

  logic signed [lrs_pkg::MulAW-1:0]  mul_a;
  logic signed [lrs_pkg::MulBW-1:0]  mul_b;
  logic [lrs_pkg::CntW-1:0]          w_idx;
  logic [lrs_pkg::FeatW-1:0]         x_sel;
  logic signed [lrs_pkg::WeightW-1:0] w_sel;
  logic [16:0]                       err;
  logic [AccW-17:0]                  z;
  logic [ZW-1:0]                     z_sat;
  logic [ZW-1:0]                     z_off;
  logic [lrs_pkg::IdxProdW-1:0]      idx_prod;
  logic [15:0]                       bias_delta;
  logic signed [65:0]                t_full;
  logic [17:0]                       w_delta;
  logic [lrs_pkg::WeightW-1:0]       bias_new;
  logic [lrs_pkg::WeightW-1:0]       w_new;

  assign w_idx = cmd_i.sel + 1'b1;
  assign x_sel = x_q[cmd_i.sel[lrs_pkg::FeatIdxW-1:0]];
  assign w_sel = w_q[w_idx];

  // p - 65536 for a positive label is {1, p} in 17-bit two's complement.
  assign err = {label_q, p_q};

  always_comb begin
    unique case (cmd_i.mul_op)
      lrs_pkg::MulDot: begin
        mul_a = {w_sel[31], w_sel};
        mul_b = {2'b00, x_sel};
      end
      lrs_pkg::MulGain: begin
        mul_a = {17'b0, p_q};
        mul_b = 18'd65536 - {2'b00, p_q};
      end
      lrs_pkg::MulErr: begin
        mul_a = {{16{err[16]}}, err};
        mul_b = {3'b000, prod_q[30:16]};
      end
      lrs_pkg::MulRate: begin
        mul_a = {prod_q[31], prod_q[31:0]};
        mul_b = {2'b00, lr_q};
      end
      lrs_pkg::MulLow: begin
        mul_a = {9'b0, c_q[23:0]};
        mul_b = {2'b00, x_sel};
      end
      lrs_pkg::MulHigh: begin
        mul_a = {{9{c_q[47]}}, c_q[47:24]};
        mul_b = {2'b00, x_sel};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Floor shift of the sum, then clamp to the table span of [-8, 8).
  always_comb begin
    z = acc_q[AccW-1:16];
    if (z[AccW-17:ZW-1] == {(AccW-16-ZW+1){z[ZW-1]}}) begin
      z_sat = z[ZW-1:0];
    end else if (z[AccW-17]) begin
      z_sat = {1'b1, {(ZW-1){1'b0}}};
    end else begin
      z_sat = {1'b0, {(ZW-1){1'b1}}};
    end
    z_off    = {~z_sat[ZW-1], z_sat[ZW-2:0]};
    idx_prod = lrs_pkg::IdxProdW'(z_off) * lrs_pkg::IdxProdW'(lrs_pkg::SigDepth);
    idx_d    = idx_prod[ZW +: lrs_pkg::SigIdxW];
  end

  // The update product is split: c * x = cH * x * 2^24 + cL * x.
  always_comb begin
    bias_delta = prod_q[47:32];
    bias_new   = lrs_pkg::sat32($signed({w_q[0][31], w_q[0]}) -
                                $signed({{17{bias_delta[15]}}, bias_delta}));
    t_full     = $signed({prod_q[41:0], 24'b0}) + $signed({25'b0, lo_q});
    w_delta    = t_full[65:48];
    w_new      = lrs_pkg::sat32($signed({w_sel[31], w_sel}) -
                                $signed({{15{w_delta[17]}}, w_delta}));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int i = 0; i < lrs_pkg::NumFeatures; i++) begin
        x_q[i] <= feat_i[i];
      end
      label_q <= label_i;
    end
    if (cmd_i.mul_en) begin
      prod_q <= mul_a * mul_b;
    end
    if (cmd_i.load) begin
      acc_q <= {{(AccW-48){w_q[0][31]}}, w_q[0], 16'b0};
    end else if (cmd_i.acc_en) begin
      acc_q <= acc_q + {{(AccW-48){prod_q[47]}}, prod_q[47:0]};
    end
    if (cmd_i.idx_ld) begin
      idx_q <= idx_d;
    end
    if (cmd_i.p_ld) begin
      p_q <= lrs_pkg::SigRom[idx_q];
    end
    if (cmd_i.bias_upd) begin
      c_q <= prod_q[47:0];
    end
    if (cmd_i.lo_ld) begin
      lo_q <= prod_q[40:0];
    end
    if (cmd_i.out_ld) begin
      out_prob_q  <= p_q;
      out_cls_q   <= p_q[15];
      out_match_q <= (p_q[15] == label_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= lrs_pkg::NumFeatures; i++) begin
        w_q[i] <= '0;
      end
      action_q    <= 1'b0;
      lr_q        <= lrs_pkg::LrReset;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        action_q <= action_i;
      end
      if (cfg_we_i) begin
        lr_q <= cfg_wdata_i;
      end
      if (cmd_i.bias_upd) begin
        w_q[0] <= bias_new;
      end
      if (cmd_i.w_upd) begin
        w_q[w_idx] <= w_new;
      end
      if (cmd_i.out_ld) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.action   = action_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o           = out_valid_q;
  assign out_probability_o     = out_prob_q;
  assign out_predicted_class_o = out_cls_q;
  assign out_matches_label_o   = out_match_q;

endmodule
